// ===== hw/rtl/bfm_pkg.sv =====
// Package for the bloom filter engine: sizes, constants and the structs
// passed between the top level and the hash unit. No dependencies.
`default_nettype none
package bfm_pkg;
  localparam int MAX_FILTER_BYTES = 32768;
  localparam int MAX_HASHES       = 50;
  localparam int MAX_KEY_WORDS    = 16;

  localparam int ADDR_W = $clog2(MAX_FILTER_BYTES);
  localparam int NB_W   = $clog2(MAX_FILTER_BYTES + 1);
  localparam int IDX_W  = ADDR_W + 3;
  localparam int NBIT_W = NB_W + 3;
  localparam int KA_W   = $clog2(MAX_KEY_WORDS);
  localparam int KCNT_W = $clog2(MAX_KEY_WORDS + 1);
  localparam int LEN_W  = $clog2(4 * MAX_KEY_WORDS + 1);
  localparam int WCNT_W = LEN_W - 1;

  localparam logic [31:0] SEED_STEP = 32'hFBA4C795;
  localparam logic [31:0] MM_C1     = 32'hcc9e2d51;
  localparam logic [31:0] MM_C2     = 32'h1b873593;
  localparam logic [31:0] MM_N      = 32'he6546b64;
  localparam logic [31:0] MM_F1     = 32'h85ebca6b;
  localparam logic [31:0] MM_F2     = 32'hc2b2ae35;
  localparam logic [7:0]  BYTE_FULL = 8'hff;

  localparam logic [1:0] REQ_INSERT  = 2'd0;
  localparam logic [1:0] REQ_QUERY   = 2'd1;
  localparam logic [1:0] REQ_REFRESH = 2'd2;
  localparam logic [1:0] REQ_IGNORED = 2'd3;

  localparam logic [1:0] CFG_TWEAK      = 2'd0;
  localparam logic [1:0] CFG_HASH_COUNT = 2'd1;
  localparam logic [1:0] CFG_FILTER     = 2'd2;

  typedef struct packed {
    logic              start;
    logic [31:0]       seed;
    logic [LEN_W-1:0]  len;
    logic [NBIT_W-1:0] nbits;
  } hash_req_t;

  typedef struct packed {
    logic             done;
    logic [IDX_W-1:0] idx;
    logic [KA_W-1:0]  kaddr;
  } hash_rsp_t;
endpackage
`default_nettype wire

// ===== hw/rtl/bfm_if.sv =====
// Valid/ready channel interfaces for the bloom filter engine.
// Depends on nothing.
`default_nettype none
interface bfm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [31:0] key_word;
  logic [2:0]  byte_count;
  logic        last;
  modport source (output valid, req_type, key_word, byte_count, last, input ready);
  modport sink   (input valid, req_type, key_word, byte_count, last, output ready);
endinterface

interface bfm_out_if;
  logic valid;
  logic ready;
  logic hit;
  logic full_now;
  logic empty_now;
  logic key_too_long;
  modport source (output valid, hit, full_now, empty_now, key_too_long, input ready);
  modport sink   (input valid, hit, full_now, empty_now, key_too_long, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/bfm_store.sv =====
// Bit store memory of the bloom filter engine: one write port and one
// registered read port. Depends on bfm_pkg.
`default_nettype none
module bfm_store
  import bfm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [7:0]        wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [7:0]        rdata
);
  logic [7:0] mem [MAX_FILTER_BYTES];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule
`default_nettype wire

// ===== hw/rtl/bfm_hash.sv =====
// MurmurHash3 x86_32 over the buffered key with one shared 32x32 multiplier,
// followed by a bit-serial remainder by the filter bit count. Depends on bfm_pkg.
`default_nettype none
module bfm_hash
  import bfm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire hash_req_t   req,
  input  wire logic [31:0] key_word,
  output hash_rsp_t        rsp
);
  typedef enum logic [3:0] {
    S_IDLE, S_NEXT, S_M1, S_M2, S_MIX, S_FM1, S_FM2, S_FM3, S_MOD
  } state_t;

  state_t            state_r, state_nxt;
  logic [31:0]       h_r, h_nxt;
  logic [31:0]       k_r, k_nxt;
  logic [WCNT_W-1:0] wcnt_r, wcnt_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [NBIT_W-1:0] nbits_r, nbits_nxt;
  logic [IDX_W-1:0]  rem_r, rem_nxt;
  logic [4:0]        bcnt_r, bcnt_nxt;
  logic              done_r, done_nxt;

  logic [31:0]       mul_a, mul_b, prod;
  logic [WCNT_W-1:0] nblocks, total;
  logic [1:0]        tail;
  logic              is_tail;
  logic [31:0]       word_m, t, hk;
  logic [NBIT_W-1:0] shifted;

  assign nblocks = WCNT_W'(len_r >> 2);
  assign tail    = len_r[1:0];
  assign total   = nblocks + WCNT_W'(tail != 2'd0);
  assign is_tail = (wcnt_r == nblocks);
  assign prod    = mul_a * mul_b;
  assign shifted = {rem_r, h_r[31]};

  always_comb begin
    case (tail)
      2'd1:    word_m = key_word & 32'h000000ff;
      2'd2:    word_m = key_word & 32'h0000ffff;
      2'd3:    word_m = key_word & 32'h00ffffff;
      default: word_m = key_word;
    endcase
    if (!is_tail) word_m = key_word;
  end

  always_comb begin
    state_nxt = state_r;
    h_nxt     = h_r;
    k_nxt     = k_r;
    wcnt_nxt  = wcnt_r;
    len_nxt   = len_r;
    nbits_nxt = nbits_r;
    rem_nxt   = rem_r;
    bcnt_nxt  = bcnt_r;
    done_nxt  = 1'b0;
    mul_a     = k_r;
    mul_b     = MM_C2;
    t         = h_r ^ 32'(len_r);
    t         = t ^ (t >> 16);
    hk        = h_r ^ k_r;
    unique case (state_r)
      S_IDLE: begin
        if (req.start) begin
          h_nxt     = req.seed;
          len_nxt   = req.len;
          nbits_nxt = req.nbits;
          wcnt_nxt  = '0;
          state_nxt = S_NEXT;
        end
      end
      S_NEXT: state_nxt = (wcnt_r < total) ? S_M1 : S_FM1;
      S_M1: begin
        mul_a     = word_m;
        mul_b     = MM_C1;
        k_nxt     = prod;
        state_nxt = S_M2;
      end
      S_M2: begin
        mul_a     = {k_r[16:0], k_r[31:17]};
        mul_b     = MM_C2;
        k_nxt     = prod;
        state_nxt = S_MIX;
      end
      S_MIX: begin
        if (is_tail) begin
          h_nxt = hk;
        end else begin
          h_nxt = {hk[18:0], hk[31:19]};
          h_nxt = (h_nxt << 2) + h_nxt + MM_N;
        end
        wcnt_nxt  = wcnt_r + 1'b1;
        state_nxt = S_NEXT;
      end
      S_FM1: begin
        mul_a     = t;
        mul_b     = MM_F1;
        k_nxt     = prod;
        state_nxt = S_FM2;
      end
      S_FM2: begin
        mul_a     = k_r ^ (k_r >> 13);
        mul_b     = MM_F2;
        k_nxt     = prod;
        state_nxt = S_FM3;
      end
      S_FM3: begin
        h_nxt     = k_r ^ (k_r >> 16);
        rem_nxt   = '0;
        bcnt_nxt  = '0;
        state_nxt = S_MOD;
      end
      S_MOD: begin
        // one quotient bit per cycle, MSB first
        if (shifted >= nbits_r) rem_nxt = IDX_W'(shifted - nbits_r);
        else                    rem_nxt = IDX_W'(shifted);
        h_nxt    = h_r << 1;
        bcnt_nxt = bcnt_r + 1'b1;
        if (bcnt_r == 5'd31) begin
          done_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    h_r     <= h_nxt;
    k_r     <= k_nxt;
    wcnt_r  <= wcnt_nxt;
    len_r   <= len_nxt;
    nbits_r <= nbits_nxt;
    rem_r   <= rem_nxt;
    bcnt_r  <= bcnt_nxt;
  end

  assign rsp.done  = done_r;
  assign rsp.idx   = rem_r;
  assign rsp.kaddr = wcnt_r[KA_W-1:0];
endmodule
`default_nettype wire

// ===== hw/rtl/bloom_filter_murmur3_core.sv =====
// Top level of the bloom filter engine: key buffer, sequencer, flags and
// output register. Depends on bfm_pkg, bfm_if, bfm_hash and bfm_store.
//
// Usage: key words arrive on in_if (valid/ready); each word of an insert or
// query key is buffered. On the word marked last the block runs up to
// hash_count (capped at MAX_HASHES) MurmurHash3 passes, a query ending at
// its first clear bit; each pass runs the shared multiplier loop, then the
// bit-serial remainder, then the hand-off, store read and update. A refresh
// scans the bytes in use. While a key or refresh runs, in_if.ready is low.
// One result leaves on out_if per completed key or refresh through an output
// register; a finished result waits there while the block takes further
// words, and a new result waits until the receiver takes the old one.
// After reset the block clears the bit store, one byte per cycle, all
// MAX_FILTER_BYTES (32768) bytes, with in_if.ready low. Configuration
// writes on cfg_* are taken at any time; the tweak is sampled with a key's
// last word; hash count and filter size also act on work in progress.
`default_nettype none
module bloom_filter_murmur3_core
  import bfm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  bfm_in_if.sink           in_if,
  bfm_out_if.source        out_if,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata
);
  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_HSTART, ST_HWAIT, ST_RD, ST_CHK, ST_REF_RD, ST_REF_CHK,
    ST_FIN
  } state_t;

  state_t             state_r;
  logic [31:0]        tweak_r;
  logic [5:0]         hash_count_r;
  logic [15:0]        filter_bytes_r;
  logic [31:0]        key_buf [MAX_KEY_WORDS];
  logic [KCNT_W-1:0]  key_len_r;
  logic               ovf_r;
  logic               full_r, empty_r;
  logic [ADDR_W-1:0]  clr_r, scan_r, addr_r;
  logic [2:0]         bit_r;
  logic               is_ins_r, hit_r, too_long_r, f_r, e_r;
  logic [31:0]        seed_r;
  logic [5:0]         hcnt_r;
  logic [LEN_W-1:0]   len_r;
  logic               start_r;
  logic               out_valid_r, out_hit_r, out_full_r, out_empty_r, out_tl_r;

  logic [NB_W-1:0]    n_use;
  logic [ADDR_W-1:0]  n_m1;
  logic [5:0]         hc_sat;
  logic [2:0]         bc_sat;
  logic               fits;
  logic [KCNT_W-1:0]  nwords;
  logic               in_xfer;
  logic               st_we;
  logic [ADDR_W-1:0]  st_waddr, st_raddr;
  logic [7:0]         st_wdata, st_rdata;
  logic               sel_bit;
  hash_req_t          hreq;
  hash_rsp_t          hrsp;

  always_comb begin
    if (filter_bytes_r == 16'd0)                       n_use = NB_W'(1);
    else if (32'(filter_bytes_r) > MAX_FILTER_BYTES)   n_use = NB_W'(MAX_FILTER_BYTES);
    else                                               n_use = NB_W'(filter_bytes_r);
  end
  assign n_m1   = ADDR_W'(n_use - 1'b1);
  assign hc_sat = (32'(hash_count_r) > MAX_HASHES) ? 6'(MAX_HASHES) : hash_count_r;
  assign bc_sat = (in_if.byte_count > 3'd4) ? 3'd4 : in_if.byte_count;
  assign fits   = (32'(key_len_r) < MAX_KEY_WORDS);
  assign nwords = key_len_r + KCNT_W'(fits);

  assign in_if.ready = (state_r == ST_IDLE);
  assign in_xfer     = in_if.valid && in_if.ready;
  assign out_if.valid        = out_valid_r;
  assign out_if.hit          = out_hit_r;
  assign out_if.full_now     = out_full_r;
  assign out_if.empty_now    = out_empty_r;
  assign out_if.key_too_long = out_tl_r;

  assign hreq.start = start_r;
  assign hreq.seed  = seed_r;
  assign hreq.len   = len_r;
  assign hreq.nbits = {n_use, 3'b000};

  bfm_hash u_hash (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (hreq),
    .key_word (key_buf[hrsp.kaddr]),
    .rsp      (hrsp)
  );

  assign sel_bit  = st_rdata[bit_r];
  assign st_we    = (state_r == ST_CLEAR) || (state_r == ST_CHK && is_ins_r);
  assign st_waddr = (state_r == ST_CLEAR) ? clr_r : addr_r;
  assign st_wdata = (state_r == ST_CLEAR) ? 8'd0 : (st_rdata | (8'd1 << bit_r));
  assign st_raddr = (state_r == ST_REF_RD) ? scan_r : addr_r;

  bfm_store u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tweak_r        <= '0;
      hash_count_r   <= '0;
      filter_bytes_r <= 16'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TWEAK:      tweak_r <= cfg_wdata;
        CFG_HASH_COUNT: hash_count_r <= cfg_wdata[5:0];
        CFG_FILTER:     filter_bytes_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && in_if.req_type != REQ_REFRESH && in_if.req_type != REQ_IGNORED && fits) begin
      key_buf[key_len_r[KA_W-1:0]] <= in_if.key_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      key_len_r   <= '0;
      ovf_r       <= 1'b0;
      full_r      <= 1'b0;
      empty_r     <= 1'b0;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      start_r <= (state_r == ST_HSTART) && (hcnt_r != hc_sat);
      if (out_valid_r && out_if.ready && state_r != ST_FIN) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == ADDR_W'(MAX_FILTER_BYTES - 1)) state_r <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_xfer) begin
            if (in_if.req_type == REQ_REFRESH) begin
              hit_r      <= 1'b0;
              too_long_r <= 1'b0;
              scan_r     <= '0;
              f_r        <= 1'b1;
              e_r        <= 1'b1;
              state_r    <= ST_REF_RD;
            end else if (in_if.req_type != REQ_IGNORED) begin
              if (!in_if.last) begin
                if (fits) key_len_r <= key_len_r + 1'b1;
                else      ovf_r <= 1'b1;
              end else begin
                key_len_r  <= '0;
                ovf_r      <= 1'b0;
                is_ins_r   <= (in_if.req_type == REQ_INSERT);
                len_r      <= LEN_W'((32'(nwords) - 1) * 4 + 32'(bc_sat));
                seed_r     <= tweak_r;
                hcnt_r     <= '0;
                too_long_r <= ovf_r || !fits;
                if (ovf_r || !fits) begin
                  hit_r   <= 1'b0;
                  state_r <= ST_FIN;
                end else if (full_r) begin
                  hit_r   <= (in_if.req_type == REQ_QUERY);
                  state_r <= ST_FIN;
                end else if (in_if.req_type == REQ_QUERY && empty_r) begin
                  hit_r   <= 1'b0;
                  state_r <= ST_FIN;
                end else begin
                  hit_r   <= (in_if.req_type == REQ_QUERY);
                  state_r <= ST_HSTART;
                end
              end
            end
          end
        end
        ST_HSTART: begin
          if (hcnt_r == hc_sat) begin
            if (is_ins_r) empty_r <= 1'b0;
            state_r <= ST_FIN;
          end else begin
            state_r <= ST_HWAIT;
          end
        end
        ST_HWAIT: begin
          if (hrsp.done) begin
            addr_r  <= hrsp.idx[IDX_W-1:3];
            bit_r   <= hrsp.idx[2:0];
            state_r <= ST_RD;
          end
        end
        ST_RD: state_r <= ST_CHK;
        ST_CHK: begin
          hcnt_r <= hcnt_r + 1'b1;
          seed_r <= seed_r + SEED_STEP;
          if (!is_ins_r && !sel_bit) begin
            hit_r   <= 1'b0;
            state_r <= ST_FIN;
          end else begin
            state_r <= ST_HSTART;
          end
        end
        ST_REF_RD: state_r <= ST_REF_CHK;
        ST_REF_CHK: begin
          if (scan_r == n_m1) begin
            full_r  <= f_r && (st_rdata == BYTE_FULL);
            empty_r <= e_r && (st_rdata == 8'd0);
            state_r <= ST_FIN;
          end else begin
            f_r     <= f_r && (st_rdata == BYTE_FULL);
            e_r     <= e_r && (st_rdata == 8'd0);
            scan_r  <= scan_r + 1'b1;
            state_r <= ST_REF_RD;
          end
        end
        ST_FIN: begin
          // hold until the output register is free
          if (!out_valid_r || out_if.ready) begin
            out_valid_r <= 1'b1;
            out_hit_r   <= hit_r;
            out_full_r  <= full_r;
            out_empty_r <= empty_r;
            out_tl_r    <= too_long_r;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_done_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    hrsp.done |-> state_r == ST_HWAIT)
    else $error("hash result arrived while not waiting");
  a_key_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(key_len_r) <= MAX_KEY_WORDS)
    else $error("key length beyond buffer");
  a_no_tl_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.key_too_long |-> !out_if.hit)
    else $error("too-long key reported a hit");
  a_start_from_hstart: assert property (@(posedge clk) disable iff (!rst_n)
    start_r |-> $past(state_r) == ST_HSTART)
    else $error("hash start outside of the hash loop");
`endif
endmodule
`default_nettype wire
